FILE: rtl/core/vfc_pkg.sv
// shared constants, types and the cube corner table for the voxel face mesher
package vfc_pkg;

	// world and chunk geometry
	localparam int CHUNK_SIDE = 16;
	localparam int WORLD_SIDE = 1024;
	localparam int WORLD_TALL = 256;

	// field widths
	localparam int COORD_W   = 10;
	localparam int Z_W       = 8;
	localparam int RGB_W     = 24;
	localparam int XY_OUT_W  = 11;
	localparam int Z_OUT_W   = 15;
	localparam int IDX_W     = 21;
	localparam int NORM_W    = 3;
	localparam int NUM_FACES = 6;

	// local coordinate inside a chunk
	localparam int LOC_W = (CHUNK_SIDE > 1) ? $clog2(CHUNK_SIDE) : 1;

	// width for world edge compares, holds WORLD_SIDE and WORLD_TALL at their maxima
	localparam int EDGE_W = 14;

	// reciprocal for coordinate mod CHUNK_SIDE, exact for every 10 bit coordinate
	localparam int RECIP_SH = 20;
	localparam int RECIP    = ((1 << RECIP_SH) + CHUNK_SIDE - 1) / CHUNK_SIDE;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = RECIP_W + COORD_W;

	// fixed point scale of vertex positions
	localparam int VERT_SCALE = 100;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [NORM_W-1:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	// one classified block waiting for the back end
	typedef struct packed {
		logic [NUM_FACES-1:0] open;
		logic                 start;
		logic [LOC_W-1:0]     loc_x;
		logic [LOC_W-1:0]     loc_y;
		logic [Z_W-1:0]       pos_z;
		logic [RGB_W-1:0]     rgb;
	} blk_t;

	// corner number for vertex k of a face: x = bit 2, y = bit 0, z = bit 1
	function automatic logic [2:0] face_corner(face_t f, logic [1:0] k);
		logic [11:0] row;
		case (f)
			FACE_PX: row = {3'd6, 3'd7, 3'd4, 3'd5};
			FACE_NX: row = {3'd3, 3'd2, 3'd1, 3'd0};
			FACE_PY: row = {3'd7, 3'd3, 3'd5, 3'd1};
			FACE_NY: row = {3'd2, 3'd6, 3'd0, 3'd4};
			FACE_PZ: row = {3'd7, 3'd6, 3'd3, 3'd2};
			FACE_NZ: row = {3'd1, 3'd0, 3'd5, 3'd4};
			default: row = '0;
		endcase
		return row[k*3 +: 3];
	endfunction

endpackage

FILE: rtl/core/voxel_face_cull_mesher.sv
// voxel face culling mesher: top level joining front end, queue and back end
// a block's first vertex passes the front stage register, the queue and the output register
// throughput: one vertex per cycle, four vertices per open face, so 4 to 24 vertices per block
//   with an open face; a block with no open face gives none; the output channel sets the pace
// reset: arst_n clears the vertex counter, the queue and all valid flags; no clearing pass
module voxel_face_cull_mesher import vfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// block channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [COORD_W-1:0]  block_x,
	input  logic [COORD_W-1:0]  block_y,
	input  logic [Z_W-1:0]      block_z,
	input  logic                self_air,
	input  logic                air_px,
	input  logic                air_nx,
	input  logic                air_py,
	input  logic                air_ny,
	input  logic                air_pz,
	input  logic                air_nz,
	input  logic [RGB_W-1:0]    block_rgb,
	input  logic                chunk_start,
	// vertex channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [XY_OUT_W-1:0] vert_x,
	output logic [XY_OUT_W-1:0] vert_y,
	output logic [Z_OUT_W-1:0]  vert_z,
	output logic [NORM_W-1:0]   normal_code,
	output logic [RGB_W-1:0]    vert_rgb,
	output logic [IDX_W-1:0]    vert_index,
	output logic                last_of_block
);

	// classified block from front end into the queue
	logic push_valid;
	logic push_ready;
	blk_t push_data;

	// head of the queue into the back end
	logic pop_valid;
	logic pop_ready;
	blk_t pop_data;

	// front end: edge tests, air masking, chunk local coords, one block per cycle unless stalled
	vfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.block_x     (block_x),
		.block_y     (block_y),
		.block_z     (block_z),
		.self_air    (self_air),
		.air_px      (air_px),
		.air_nx      (air_nx),
		.air_py      (air_py),
		.air_ny      (air_ny),
		.air_pz      (air_pz),
		.air_nz      (air_nz),
		.block_rgb   (block_rgb),
		.chunk_start (chunk_start),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// queue lets the front keep taking blocks while the back works through a busy one
	vfc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back end: face walk, vertex counter and registered output stage
	vfc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.vert_z        (vert_z),
		.normal_code   (normal_code),
		.vert_rgb      (vert_rgb),
		.vert_index    (vert_index),
		.last_of_block (last_of_block)
	);

endmodule

FILE: rtl/core/vfc_front.sv
// front end: takes blocks, works out open faces and chunk local coordinates
module vfc_front import vfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] block_x,
	input  logic [COORD_W-1:0] block_y,
	input  logic [Z_W-1:0]     block_z,
	input  logic               self_air,
	input  logic               air_px,
	input  logic               air_nx,
	input  logic               air_py,
	input  logic               air_ny,
	input  logic               air_pz,
	input  logic               air_nz,
	input  logic [RGB_W-1:0]   block_rgb,
	input  logic               chunk_start,
	output logic               push_valid,
	input  logic               push_ready,
	output blk_t               push_data
);

	logic [NUM_FACES-1:0] open_d;
	logic [PROD_W-1:0]    prod_x;
	logic [PROD_W-1:0]    prod_y;
	logic                 take;

	logic                 s1_valid_q;
	logic [NUM_FACES-1:0] open_s1;
	logic                 start_s1;
	logic [COORD_W-1:0]   bx_s1;
	logic [COORD_W-1:0]   by_s1;
	logic [COORD_W-1:0]   qx_s1;
	logic [COORD_W-1:0]   qy_s1;
	logic [Z_W-1:0]       bz_s1;
	logic [RGB_W-1:0]     rgb_s1;

	// faces at the world edge stay closed, and an air block opens none
	always_comb begin
		open_d[FACE_PX] = air_px && ((EDGE_W'(block_x) + EDGE_W'(1)) < EDGE_W'(WORLD_SIDE));
		open_d[FACE_NX] = air_nx && (block_x != '0);
		open_d[FACE_PY] = air_py && ((EDGE_W'(block_y) + EDGE_W'(1)) < EDGE_W'(WORLD_SIDE));
		open_d[FACE_NY] = air_ny && (block_y != '0);
		open_d[FACE_PZ] = air_pz && ((EDGE_W'(block_z) + EDGE_W'(1)) < EDGE_W'(WORLD_TALL));
		open_d[FACE_NZ] = air_nz && (block_z != '0);
		if (self_air) begin
			open_d = '0;
		end
	end

	// quotient by chunk side through the reciprocal
	assign prod_x = PROD_W'(RECIP) * PROD_W'(block_x);
	assign prod_y = PROD_W'(RECIP) * PROD_W'(block_y);

	assign in_ready = !s1_valid_q || push_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			open_s1  <= open_d;
			start_s1 <= chunk_start;
			bx_s1    <= block_x;
			by_s1    <= block_y;
			qx_s1    <= prod_x[RECIP_SH +: COORD_W];
			qy_s1    <= prod_y[RECIP_SH +: COORD_W];
			bz_s1    <= block_z;
			rgb_s1   <= block_rgb;
		end
	end

	assign push_valid      = s1_valid_q;
	assign push_data.open  = open_s1;
	assign push_data.start = start_s1;
	assign push_data.loc_x = LOC_W'(bx_s1 - COORD_W'(qx_s1 * COORD_W'(CHUNK_SIDE)));
	assign push_data.loc_y = LOC_W'(by_s1 - COORD_W'(qy_s1 * COORD_W'(CHUNK_SIDE)));
	assign push_data.pos_z = bz_s1;
	assign push_data.rgb   = rgb_s1;

endmodule

FILE: rtl/core/vfc_fifo.sv
// short register queue of classified blocks between front and back
module vfc_fifo import vfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  blk_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output blk_t pop_data
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	blk_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/vfc_back.sv
// back end: walks the open faces of a block and emits four vertices per face
module vfc_back import vfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  blk_t                pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [XY_OUT_W-1:0] vert_x,
	output logic [XY_OUT_W-1:0] vert_y,
	output logic [Z_OUT_W-1:0]  vert_z,
	output logic [NORM_W-1:0]   normal_code,
	output logic [RGB_W-1:0]    vert_rgb,
	output logic [IDX_W-1:0]    vert_index,
	output logic                last_of_block
);

	logic                 active_q;
	logic [NUM_FACES-1:0] mask_q;
	logic [1:0]           k_q;
	logic [IDX_W-1:0]     cnt_q;

	logic                 out_valid_q;
	logic [XY_OUT_W-1:0]  vx_q;
	logic [XY_OUT_W-1:0]  vy_q;
	logic [Z_OUT_W-1:0]   vz_q;
	logic [NORM_W-1:0]    norm_q;
	logic [RGB_W-1:0]     rgb_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 last_q;

	logic [NUM_FACES-1:0] eff_mask;
	logic [NUM_FACES-1:0] mask_next;
	logic [IDX_W-1:0]     eff_cnt;
	face_t                face_sel;
	logic [2:0]           corner;
	logic                 out_space;
	logic                 no_face;
	logic                 go;
	logic                 done;
	logic                 emit;
	logic [LOC_W:0]       sum_x;
	logic [LOC_W:0]       sum_y;
	logic [Z_W:0]         sum_z;

	// the head entry stays in the queue until its last vertex goes out
	assign eff_mask = active_q ? mask_q : pop_data.open;
	assign eff_cnt  = (!active_q && pop_data.start) ? '0 : cnt_q;
	assign no_face  = (eff_mask == '0);

	always_comb begin
		logic found;
		found    = 1'b0;
		face_sel = FACE_PX;
		for (int i = 0; i < NUM_FACES; i++) begin
			if (eff_mask[i] && !found) begin
				face_sel = face_t'(NORM_W'(i));
				found    = 1'b1;
			end
		end
	end

	assign mask_next = (k_q == 2'd3) ? (eff_mask & ~(NUM_FACES'(1) << face_sel)) : eff_mask;
	assign out_space = !out_valid_q || out_ready;
	assign go        = pop_valid && (no_face || out_space);
	assign done      = no_face || (mask_next == '0);
	assign emit      = go && !no_face;
	assign pop_ready = go && done;

	assign corner = face_corner(face_sel, k_q);
	assign sum_x  = (LOC_W+1)'(pop_data.loc_x) + (LOC_W+1)'(corner[2]);
	assign sum_y  = (LOC_W+1)'(pop_data.loc_y) + (LOC_W+1)'(corner[0]);
	assign sum_z  = (Z_W+1)'(pop_data.pos_z) + (Z_W+1)'(corner[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			mask_q      <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				if (no_face) begin
					cnt_q    <= eff_cnt;
					active_q <= 1'b0;
				end else begin
					cnt_q    <= eff_cnt + IDX_W'(1);
					k_q      <= k_q + 2'd1;
					mask_q   <= mask_next;
					active_q <= !done;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			vx_q   <= XY_OUT_W'(sum_x * VERT_SCALE);
			vy_q   <= XY_OUT_W'(sum_y * VERT_SCALE);
			vz_q   <= Z_OUT_W'(sum_z * VERT_SCALE);
			norm_q <= face_sel;
			rgb_q  <= pop_data.rgb;
			idx_q  <= eff_cnt;
			last_q <= done;
		end
	end

	assign out_valid     = out_valid_q;
	assign vert_x        = vx_q;
	assign vert_y        = vy_q;
	assign vert_z        = vz_q;
	assign normal_code   = norm_q;
	assign vert_rgb      = rgb_q;
	assign vert_index    = idx_q;
	assign last_of_block = last_q;

endmodule

FILE: rtl/core/vfc_checker.sv
// port level checks on the voxel face mesher and their binding to the top level
module vfc_checker import vfc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [XY_OUT_W-1:0] vert_x,
	input logic [NORM_W-1:0]   normal_code,
	input logic [IDX_W-1:0]    vert_index,
	input logic                last_of_block
);

	// stalled vertex holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vert_index) && $stable(vert_x)
			&& $stable(normal_code) && $stable(last_of_block))
		else $error("vertex changed while stalled");

	// quads start on a multiple of four, so a block always ends on a quad's fourth vertex
	a_last_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_block |-> vert_index[1:0] == 2'd3)
		else $error("block ended inside a quad");

	// the rest of a quad follows at once with the same face and the next index
	a_quad_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && vert_index[1:0] != 2'd3
			|=> out_valid && $stable(normal_code)
			&& (vert_index == $past(vert_index) + IDX_W'(1)))
		else $error("quad broken up");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_code <= NORM_W'(NUM_FACES - 1))
		else $error("normal code out of range");

endmodule

bind voxel_face_cull_mesher vfc_checker u_vfc_checker (.*);
